// ===== src/relu_neuron_sgd_momentum_unit_defines.svh =====
// ----------------------------------------------------------------------------
// relu neuron assertion macros
// shared concurrent assertion shorthands, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef RELU_NEURON_SGD_MOMENTUM_UNIT_DEFINES_SVH
`define RELU_NEURON_SGD_MOMENTUM_UNIT_DEFINES_SVH

// same-cycle implication
`define RNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RNS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rns_pkg.sv =====
// ----------------------------------------------------------------------------
// relu neuron package
// widths, codes, types and saturation helpers shared by the neuron modules
// ----------------------------------------------------------------------------
`default_nettype none

package rns_pkg;

  localparam int DATA_W         = 16;
  localparam int FRAC_W         = 12;
  localparam int ACC_W          = 40;
  localparam int RATE_W         = 16;
  localparam int IDX_W          = 8;
  localparam int FUNC_W         = 3;
  localparam int FAN_W          = 9;
  localparam int ACT_W          = DATA_W - 1;
  localparam int MAX_FAN_IN_DEF = 256;

  localparam int GRAD_LO_W = ACC_W / 2;
  localparam int GRAD_HI_W = ACC_W - GRAD_LO_W;

  // input beat layout
  localparam int IDX_LSB    = 0;
  localparam int VAL_LSB    = IDX_LSB + IDX_W;
  localparam int GRD_LSB    = VAL_LSB + DATA_W;
  localparam int AOUT_LSB   = GRD_LSB + DATA_W;
  localparam int IN_DATA_W  = ((AOUT_LSB + DATA_W + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_FLD_W  = DATA_W + ACT_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAN = 2'd2;

  localparam logic [RATE_W-1:0] LR_RST  = 16'd655;
  localparam logic [RATE_W-1:0] MOM_RST = 16'd58982;
  localparam logic [FAN_W-1:0]  FAN_RST = 9'd256;

  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_UPD = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_W = 3'd0,
    FN_LOAD_B = 3'd1,
    FN_FWD    = 3'd2,
    FN_BWD    = 3'd3,
    FN_UPDATE = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic vld;
    logic bias;
    logic act;
  } step_tag_t;

  function automatic logic signed [DATA_W-1:0] sat_dw(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[DATA_W-1:0];
    end else if (x < lo) begin
      return lo[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) begin
      return hi[ACC_W-1:0];
    end else if (x < lo) begin
      return lo[ACC_W-1:0];
    end
    return x[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/relu_neuron_sgd_momentum_unit.sv =====
// ----------------------------------------------------------------------------
// relu neuron with momentum sgd
// one trainable relu neuron: weight loads, forward mac, backward gradient
// sums and a momentum update sweep over the parameter memories
// ----------------------------------------------------------------------------
// in_*  : command beats, func in tuser, last element flag in tlast
// out_* : forward results (kind 0) and update done (kind 1) in tuser
// cfg_* : register writes, taken on any cycle with cfg_we high
// load weight, load bias and unknown codes are done on acceptance in ST_IDLE
// forward and backward elements pass through operand memory read, multiply
//   and accumulate; backward ones read-modify-write the gradient memory
// a last forward element loads its result from accumulate once the output is free
// update sweeps one memory entry per cycle through
//   a two stage step pipeline, the bias in the slot after the last entry
// after reset a clearing pass over every entry zeroes the weight, gradient and
//   momentum memories while in_tready stays low
// the output register holds one result; while it is stalled, items that
//   give no result are still taken, one that gives a result waits
// ----------------------------------------------------------------------------
`default_nettype none
`include "relu_neuron_sgd_momentum_unit_defines.svh"

module relu_neuron_sgd_momentum_unit #(
  parameter int MAX_FAN_IN = rns_pkg::MAX_FAN_IN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rns_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rns_pkg::IN_DATA_W-1:0]    in_tdata,   // index, value, grad, act_out
  input  logic [rns_pkg::FUNC_W-1:0]       in_tuser,   // func
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rns_pkg::OUT_DATA_W-1:0]   out_tdata,  // net_value, activation, zero pad
  output logic                             out_tuser   // kind
);

  import rns_pkg::*;

  localparam int AW = (MAX_FAN_IN > 1) ? $clog2(MAX_FAN_IN) : 1;
  localparam int CW = $clog2(MAX_FAN_IN + 2);
  localparam int PW = 2 * DATA_W;

  // configuration
  logic [RATE_W-1:0] lr_r;
  logic [RATE_W-1:0] mom_r;
  logic [FAN_W-1:0]  fan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RST;
      mom_r <= MOM_RST;
      fan_r <= FAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LR:  lr_r  <= cfg_wdata[RATE_W-1:0];
        REG_MOM: mom_r <= cfg_wdata[RATE_W-1:0];
        REG_FAN: fan_r <= cfg_wdata[FAN_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat
  logic                     accept;
  logic [FUNC_W-1:0]        in_func;
  logic [IDX_W-1:0]         in_idx;
  logic signed [DATA_W-1:0] in_val;
  logic signed [DATA_W-1:0] in_grd;
  logic signed [DATA_W-1:0] in_aout;

  assign accept  = in_tvalid && in_tready;
  assign in_func = in_tuser;
  assign in_idx  = in_tdata[IDX_LSB +: IDX_W];
  assign in_val  = $signed(in_tdata[VAL_LSB +: DATA_W]);
  assign in_grd  = $signed(in_tdata[GRD_LSB +: DATA_W]);
  assign in_aout = $signed(in_tdata[AOUT_LSB +: DATA_W]);

  logic [FUNC_W-1:0]        it_func_r;
  logic [IDX_W-1:0]         it_idx_r;
  logic signed [DATA_W-1:0] it_val_r;
  logic signed [DATA_W-1:0] it_grd_r;
  logic signed [DATA_W-1:0] it_aout_r;
  logic                     it_last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_func_r <= in_func;
      it_idx_r  <= in_idx;
      it_val_r  <= in_val;
      it_grd_r  <= in_grd;
      it_aout_r <= in_aout;
      it_last_r <= in_tlast;
    end
  end

  // control
  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  logic out_valid_r;
  logic out_free;
  logic it_fwd;
  logic it_act;
  logic acc_adv;
  logic cnt_in_mem;
  logic cnt_act;

  step_tag_t                stp_res_tag;
  logic [AW-1:0]            stp_res_addr;
  logic signed [DATA_W-1:0] stp_res_w;
  logic signed [DATA_W-1:0] stp_res_m;
  logic                     stp_bias_done;

  assign out_free      = !out_valid_r || out_tready;
  assign it_fwd        = (it_func_r == FN_FWD);
  assign it_act        = (32'(it_idx_r) < 32'(fan_r)) && (32'(it_idx_r) < MAX_FAN_IN);
  assign acc_adv       = !(it_fwd && it_last_r) || out_free;
  assign cnt_in_mem    = 32'(cnt_r) < MAX_FAN_IN;
  assign cnt_act       = cnt_in_mem && (32'(cnt_r) < 32'(fan_r));
  assign stp_bias_done = stp_res_tag.vld && stp_res_tag.bias;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (32'(cnt_r) == MAX_FAN_IN - 1) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FN_FWD, FN_BWD: state_nxt = ST_MUL;
            FN_UPDATE: begin
              state_nxt = ST_UPD;
              cnt_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (acc_adv) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UPD: begin
        if (32'(cnt_r) <= MAX_FAN_IN) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        if (stp_bias_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory and issue controls
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 prm_we_w;
  logic                 prm_we_m;
  logic [AW-1:0]        prm_wa;
  logic [DATA_W-1:0]    prm_wd_w;
  logic [DATA_W-1:0]    prm_wd_m;
  logic                 grd_we;
  logic [AW-1:0]        grd_wa;
  logic [ACC_W-1:0]     grd_wd;
  step_tag_t            iss_tag;
  logic signed [ACC_W-1:0] grd_sum;

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = cnt_r[AW-1:0];
    prm_we_w  = 1'b0;
    prm_we_m  = 1'b0;
    prm_wa    = cnt_r[AW-1:0];
    prm_wd_w  = '0;
    prm_wd_m  = '0;
    grd_we    = 1'b0;
    grd_wa    = cnt_r[AW-1:0];
    grd_wd    = '0;
    iss_tag   = '0;
    unique case (state_r)
      ST_CLEAR: begin
        prm_we_w = 1'b1;
        prm_we_m = 1'b1;
        grd_we   = 1'b1;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_en     = accept;
        rd_addr   = AW'(in_idx);
        if (accept && in_func == FN_LOAD_W && 32'(in_idx) < MAX_FAN_IN) begin
          prm_we_w = 1'b1;
          prm_wa   = AW'(in_idx);
          prm_wd_w = in_val;
        end
      end
      ST_ACC: begin
        if (acc_adv && !it_fwd && it_act) begin
          grd_we = 1'b1;
          grd_wa = AW'(it_idx_r);
          grd_wd = grd_sum;
        end
      end
      ST_UPD: begin
        rd_en        = 1'b1;
        iss_tag.vld  = 32'(cnt_r) <= MAX_FAN_IN;
        iss_tag.bias = 32'(cnt_r) == MAX_FAN_IN;
        iss_tag.act  = cnt_act;
        grd_we       = cnt_in_mem;
      end
      default: ;
    endcase
    if (stp_res_tag.vld && stp_res_tag.act) begin
      prm_we_w = 1'b1;
      prm_we_m = 1'b1;
      prm_wa   = stp_res_addr;
      prm_wd_w = stp_res_w;
      prm_wd_m = stp_res_m;
    end
  end

  // parameter memory {weight, momentum} and gradient memory
  logic [PW-1:0]    prm_mem [MAX_FAN_IN];
  logic [ACC_W-1:0] grd_mem [MAX_FAN_IN];
  logic [PW-1:0]    prm_rd_r;
  logic [ACC_W-1:0] grd_rd_r;

  always_ff @(posedge clk) begin
    if (prm_we_w) begin
      prm_mem[prm_wa][PW-1:DATA_W] <= prm_wd_w;
    end
    if (prm_we_m) begin
      prm_mem[prm_wa][DATA_W-1:0] <= prm_wd_m;
    end
    if (rd_en) begin
      prm_rd_r <= prm_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (grd_we) begin
      grd_mem[grd_wa] <= grd_wd;
    end
    if (rd_en) begin
      grd_rd_r <= grd_mem[rd_addr];
    end
  end

  // forward and backward datapath
  logic signed [DATA_W-1:0]   bias_w_r;
  logic signed [DATA_W-1:0]   bias_m_r;
  logic signed [ACC_W-1:0]    bias_g_r;
  logic signed [ACC_W-1:0]    net_acc_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [DATA_W-1:0]   delta_r;

  logic signed [DATA_W-1:0]   w_rd;
  logic signed [DATA_W-1:0]   delta;
  logic signed [DATA_W-1:0]   mul_a;
  logic signed [ACC_W-1:0]    acc_base;
  logic signed [2*DATA_W-1:0] acc_add;
  logic signed [ACC_W-1:0]    net_nxt;
  logic signed [DATA_W-1:0]   net_q;
  logic [ACT_W-1:0]           act_q;
  logic signed [ACC_W-1:0]    bias_g_sum;

  assign w_rd  = $signed(prm_rd_r[PW-1:DATA_W]);
  assign delta = (it_aout_r > 0) ? it_grd_r : '0;
  assign mul_a = it_fwd ? w_rd : delta;

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r  <= mul_a * it_val_r;
      delta_r <= delta;
    end
  end

  assign acc_base   = (it_idx_r == '0) ? (ACC_W'(bias_w_r) <<< FRAC_W) : net_acc_r;
  assign acc_add    = it_act ? prod_r : '0;
  assign net_nxt    = sat_acc(64'(acc_base) + 64'(acc_add));
  assign net_q      = sat_dw(64'(net_nxt >>> FRAC_W));
  assign act_q      = (net_q > 0) ? net_q[ACT_W-1:0] : '0;
  assign grd_sum    = sat_acc(64'($signed(grd_rd_r)) + 64'(prod_r));
  assign bias_g_sum = sat_acc(64'(bias_g_r) + (64'(delta_r) <<< FRAC_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      net_acc_r <= '0;
      bias_g_r  <= '0;
      bias_m_r  <= '0;
    end else begin
      if (state_r == ST_ACC && acc_adv) begin
        if (it_fwd) begin
          net_acc_r <= net_nxt;
        end else if (it_last_r) begin
          bias_g_r <= bias_g_sum;
        end
      end
      if (stp_bias_done) begin
        bias_g_r <= '0;
        bias_m_r <= stp_res_m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_func == FN_LOAD_B) begin
      bias_w_r <= in_val;
    end else if (stp_bias_done) begin
      bias_w_r <= stp_res_w;
    end
  end

  // update sweep: operands in the cycle after the memory read
  step_tag_t     iss_tag_r;
  logic [AW-1:0] iss_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_tag_r <= '0;
    end else begin
      iss_tag_r <= iss_tag;
    end
  end

  always_ff @(posedge clk) begin
    iss_addr_r <= cnt_r[AW-1:0];
  end

  rns_step #(
    .MAX_FAN_IN (MAX_FAN_IN)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_tag   (iss_tag_r),
    .op_addr  (iss_addr_r),
    .op_w     (iss_tag_r.bias ? bias_w_r : $signed(prm_rd_r[PW-1:DATA_W])),
    .op_m     (iss_tag_r.bias ? bias_m_r : $signed(prm_rd_r[DATA_W-1:0])),
    .op_g     (iss_tag_r.bias ? bias_g_r : $signed(grd_rd_r)),
    .op_lr    (lr_r),
    .op_mom   (mom_r),
    .res_tag  (stp_res_tag),
    .res_addr (stp_res_addr),
    .res_w    (stp_res_w),
    .res_m    (stp_res_m)
  );

  // output register
  logic                     out_load;
  logic                     out_kind_r;
  logic signed [DATA_W-1:0] out_net_r;
  logic [ACT_W-1:0]         out_act_r;

  assign out_load = ((state_r == ST_ACC) && it_fwd && it_last_r && out_free)
                 || ((state_r == ST_FIN) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_FIN) begin
        out_kind_r <= KIND_UPD;
        out_net_r  <= '0;
        out_act_r  <= '0;
      end else begin
        out_kind_r <= KIND_FWD;
        out_net_r  <= net_q;
        out_act_r  <= act_q;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_act_r, out_net_r};

  `RNS_ASSERT_IMP(a_wb_in_update, stp_res_tag.vld, state_r == ST_UPD, "step write-back outside update")
  `RNS_ASSERT_NXT(a_fwd_result, (state_r == ST_ACC) && it_fwd && it_last_r && acc_adv, out_tvalid && (out_tuser == KIND_FWD), "forward result not presented")
  `RNS_ASSERT_IMP(a_fin_drained, state_r == ST_FIN, (bias_g_r == '0) && !iss_tag_r.vld && !stp_res_tag.vld, "update finished with work in flight")

endmodule

`default_nettype wire

// ===== src/rns_step.sv =====
// ----------------------------------------------------------------------------
// relu neuron parameter step pipeline
// two register stages computing m = sat(mom*m + lr*g) and w = sat(w + m)
// ----------------------------------------------------------------------------
`default_nettype none

module rns_step #(
  parameter int MAX_FAN_IN = rns_pkg::MAX_FAN_IN_DEF,
  localparam int AW = (MAX_FAN_IN > 1) ? $clog2(MAX_FAN_IN) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rns_pkg::step_tag_t                 op_tag,
  input  logic [AW-1:0]                      op_addr,
  input  logic signed [rns_pkg::DATA_W-1:0]  op_w,
  input  logic signed [rns_pkg::DATA_W-1:0]  op_m,
  input  logic signed [rns_pkg::ACC_W-1:0]   op_g,
  input  logic [rns_pkg::RATE_W-1:0]         op_lr,
  input  logic [rns_pkg::RATE_W-1:0]         op_mom,
  output rns_pkg::step_tag_t                 res_tag,
  output logic [AW-1:0]                      res_addr,
  output logic signed [rns_pkg::DATA_W-1:0]  res_w,
  output logic signed [rns_pkg::DATA_W-1:0]  res_m
);

  import rns_pkg::*;

  localparam int PM_W  = RATE_W + 1 + DATA_W;
  localparam int PLO_W = RATE_W + GRAD_LO_W;
  localparam int PHI_W = RATE_W + 1 + GRAD_HI_W;
  localparam int SUM_W = RATE_W + ACC_W + 2;

  step_tag_t               a_tag_r;
  step_tag_t               b_tag_r;
  logic [AW-1:0]           a_addr_r;
  logic [AW-1:0]           b_addr_r;
  logic signed [DATA_W-1:0] a_w_r;
  logic signed [DATA_W-1:0] b_w_r;
  logic signed [PM_W-1:0]  a_pm_r;
  logic [PLO_W-1:0]        a_plo_r;
  logic signed [PHI_W-1:0] a_phi_r;
  logic signed [SUM_W-1:0] b_sum_r;

  logic signed [PM_W-1:0]  pm;
  logic [PLO_W-1:0]        plo;
  logic signed [PHI_W-1:0] phi;
  logic signed [SUM_W-1:0] sum;

  // lr*g split into two narrow products
  assign pm  = $signed({1'b0, op_mom}) * op_m;
  assign plo = op_lr * op_g[GRAD_LO_W-1:0];
  assign phi = $signed({1'b0, op_lr}) * $signed(op_g[ACC_W-1:GRAD_LO_W]);

  assign sum = (SUM_W'(a_pm_r) <<< FRAC_W) + (SUM_W'(a_phi_r) <<< GRAD_LO_W)
             + $signed(SUM_W'(a_plo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
      b_tag_r <= '0;
    end else begin
      a_tag_r <= op_tag;
      b_tag_r <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    a_addr_r <= op_addr;
    a_w_r    <= op_w;
    a_pm_r   <= pm;
    a_plo_r  <= plo;
    a_phi_r  <= phi;
    b_addr_r <= a_addr_r;
    b_w_r    <= a_w_r;
    b_sum_r  <= sum;
  end

  assign res_tag  = b_tag_r;
  assign res_addr = b_addr_r;
  assign res_m    = sat_dw(64'(b_sum_r >>> (RATE_W + FRAC_W)));
  assign res_w    = sat_dw(64'(b_w_r) + 64'(res_m));

endmodule

`default_nettype wire
